// ===== hdl/sfr_pkg.sv =====
`default_nettype none

package sfr_pkg;

  // output field widths
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SUM_W  = 32;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_BYTE    = 2'd0;
  localparam logic [1:0] CFG_ESCAPE_BYTE   = 2'd1;
  localparam logic [1:0] CFG_CHECKSUM_SEED = 2'd2;

  // configuration reset values
  localparam logic [BYTE_W-1:0] FRAME_BYTE_RST  = 8'd126;
  localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST = 8'd125;
  localparam logic [SUM_W-1:0]  SEED_RST        = 32'd0;

  // frame result codes
  typedef enum logic [1:0] {
    STAT_GOOD     = 2'd0,
    STAT_BAD_SUM  = 2'd1,
    STAT_TOO_FEW  = 2'd2,
    STAT_TOO_MANY = 2'd3
  } status_t;

  // checksum fold step selects
  typedef enum logic [1:0] {
    FOLD_HOLD = 2'd0,
    FOLD_SUB  = 2'd1,
    FOLD_S16  = 2'd2,
    FOLD_S8   = 2'd3
  } fold_op_t;

  // controller states
  typedef enum logic [3:0] {
    ST_RUN,
    ST_SUB,
    ST_F16A,
    ST_F16B,
    ST_F8A,
    ST_F8B,
    ST_DECIDE,
    ST_READ,
    ST_LOAD,
    ST_ERR
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic     accept;
    logic     restart;
    fold_op_t fold_op;
    logic     idx_inc;
    logic     out_load;
    logic     out_err;
  } sfr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_end;
    logic frame_good;
    logic last_byte;
    logic out_free;
  } sfr_stat_t;

endpackage

`default_nettype wire

// ===== hdl/sfr_ram.sv =====
`default_nettype none

module sfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/sfr_ctrl.sv =====
`default_nettype none

module sfr_ctrl
  import sfr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire sfr_stat_t stat,
  output sfr_cmd_t       cmd
);

  state_t state_r, state_nxt;

  // bytes are taken only while collecting a frame
  assign in_ready = (state_r == ST_RUN);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (in_valid && stat.frame_end) state_nxt = ST_SUB;
      end
      ST_SUB:    state_nxt = ST_F16A;
      ST_F16A:   state_nxt = ST_F16B;
      ST_F16B:   state_nxt = ST_F8A;
      ST_F8A:    state_nxt = ST_F8B;
      ST_F8B:    state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = stat.frame_good ? ST_READ : ST_ERR;
      ST_READ:   state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (stat.out_free) state_nxt = stat.last_byte ? ST_RUN : ST_READ;
      end
      ST_ERR: begin
        if (stat.out_free) state_nxt = ST_RUN;
      end
      default:   state_nxt = ST_RUN;
    endcase
  end

  // command outputs
  always_comb begin
    cmd          = '0;
    cmd.fold_op  = FOLD_HOLD;
    cmd.accept   = in_valid && in_ready;
    unique case (state_r)
      ST_SUB:  cmd.fold_op = FOLD_SUB;
      ST_F16A: cmd.fold_op = FOLD_S16;
      ST_F16B: cmd.fold_op = FOLD_S16;
      ST_F8A:  cmd.fold_op = FOLD_S8;
      ST_F8B:  cmd.fold_op = FOLD_S8;
      ST_LOAD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.restart  = stat.last_byte;
          cmd.idx_inc  = !stat.last_byte;
        end
      end
      ST_ERR: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_err  = 1'b1;
          cmd.restart  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sfr_datapath.sv =====
`default_nettype none

module sfr_datapath
  import sfr_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES   = 64,
  parameter int unsigned MIN_BODY_BYTES = 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [SUM_W-1:0]  cfg_data,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic      [1:0]        out_status,
  output logic      [BYTE_W-1:0] out_data_byte,
  output logic      [IDX_W-1:0]  out_byte_index,
  output logic      [IDX_W-1:0]  out_frame_length,
  output logic                   out_last_item,
  input  wire sfr_cmd_t          cmd,
  output sfr_stat_t              stat
);

  localparam int unsigned HALF_BUF = (BUFFER_BYTES / 2) < 32 ? (BUFFER_BYTES / 2) : 32;
  localparam int unsigned CW       = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned AW       = $clog2(HALF_BUF);
  localparam int unsigned EW       = CW > IDX_W ? CW : IDX_W;

  // configuration registers
  logic [BYTE_W-1:0] frame_byte_r, escape_byte_r;
  logic [SUM_W-1:0]  seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_byte_r  <= FRAME_BYTE_RST;
      escape_byte_r <= ESCAPE_BYTE_RST;
      seed_r        <= SEED_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_BYTE:    frame_byte_r  <= cfg_data[BYTE_W-1:0];
        CFG_ESCAPE_BYTE:   escape_byte_r <= cfg_data[BYTE_W-1:0];
        CFG_CHECKSUM_SEED: seed_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame state
  logic [CW-1:0]     count_r, count_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [BYTE_W-1:0] newest_r, newest_nxt;
  logic              esc_r, esc_nxt;
  logic [SUM_W-1:0]  fold_r, fold_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  // byte classification
  logic is_frame, is_escape, set_esc, store_en, ram_we;

  assign is_frame  = (in_rx_byte == frame_byte_r);
  assign is_escape = (in_rx_byte == escape_byte_r);
  assign set_esc   = !is_frame && is_escape && !esc_r;
  assign store_en  = cmd.accept && !stat.frame_end && !set_esc &&
                     (count_r < CW'(BUFFER_BYTES));
  assign ram_we    = store_en && (count_r < CW'(HALF_BUF));

  // frame store
  logic [BYTE_W-1:0] rd_data;

  sfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (HALF_BUF)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_rx_byte),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  // frame verdict and length
  logic [EW-1:0]    count_ext, len_ext;
  logic [IDX_W-1:0] len;
  logic             too_few, too_many, sum_ok;
  status_t          code;

  assign count_ext = EW'(count_r);
  assign len_ext   = (count_r == '0) ? '0 : count_ext - EW'(1);
  assign too_few   = count_r < CW'(MIN_BODY_BYTES + 1);
  assign too_many  = count_r > CW'(HALF_BUF);
  assign sum_ok    = (fold_r[BYTE_W-1:0] == newest_r);
  assign len       = (too_many && !too_few) ? '1 : len_ext[IDX_W-1:0];

  always_comb begin
    priority if (too_few) code = STAT_TOO_FEW;
    else if (too_many)    code = STAT_TOO_MANY;
    else if (!sum_ok)     code = STAT_BAD_SUM;
    else                  code = STAT_GOOD;
  end

  // status to controller
  assign stat.frame_end  = is_frame && !esc_r;
  assign stat.frame_good = (code == STAT_GOOD);
  assign stat.last_byte  = (idx_r == len - IDX_W'(1));
  assign stat.out_free   = !out_valid || out_ready;

  // frame state update
  always_comb begin
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    newest_nxt = newest_r;
    esc_nxt    = esc_r;
    idx_nxt    = idx_r;
    if (cmd.restart) begin
      count_nxt  = '0;
      sum_nxt    = seed_r;
      newest_nxt = '0;
      esc_nxt    = 1'b0;
      idx_nxt    = '0;
    end else begin
      if (cmd.accept && !stat.frame_end) esc_nxt = set_esc;
      if (store_en) begin
        count_nxt  = count_r + CW'(1);
        sum_nxt    = sum_r + SUM_W'(in_rx_byte);
        newest_nxt = in_rx_byte;
      end
      if (cmd.idx_inc) idx_nxt = idx_r + IDX_W'(1);
    end
  end

  // end-around fold, one add per cycle
  always_comb begin
    unique case (cmd.fold_op)
      FOLD_SUB:  fold_nxt = sum_r - SUM_W'(newest_r);
      FOLD_S16:  fold_nxt = fold_r + {16'd0, fold_r[31:16]};
      FOLD_S8:   fold_nxt = fold_r + {8'd0, fold_r[31:8]};
      FOLD_HOLD: fold_nxt = fold_r;
      default:   fold_nxt = fold_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sum_r    <= SEED_RST;
      newest_r <= '0;
      esc_r    <= 1'b0;
      idx_r    <= '0;
    end else begin
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
      newest_r <= newest_nxt;
      esc_r    <= esc_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fold_r <= fold_nxt;
  end

  // output word register
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)     out_valid_nxt = 1'b1;
    else if (out_ready)   out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_frame_length <= len;
      if (cmd.out_err) begin
        out_status     <= code;
        out_data_byte  <= '0;
        out_byte_index <= '0;
        out_last_item  <= 1'b1;
      end else begin
        out_status     <= STAT_GOOD;
        out_data_byte  <= rd_data;
        out_byte_index <= idx_r;
        out_last_item  <= stat.last_byte;
      end
    end
  end

  assign out_valid = out_valid_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(BUFFER_BYTES))
    else $error("stored count past buffer size");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("output word overwritten before taken");

  a_good_index: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && !cmd.out_err) |=>
      (out_byte_index < out_frame_length) && (out_status == STAT_GOOD))
    else $error("good frame word index out of range");

  a_no_store_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fold_op != FOLD_HOLD) |-> !cmd.accept)
    else $error("byte taken while checksum folds");

endmodule

`default_nettype wire

// ===== hdl/stuffed_frame_receiver.sv =====
`default_nettype none

// channel   direction  handshake               payload
// in_       input      in_valid / in_ready     in_rx_byte[7:0]
// out_      output     out_valid / out_ready   out_status[1:0], out_data_byte[7:0],
//                                              out_byte_index[4:0],
//                                              out_frame_length[4:0], out_last_item
// cfg_      input      cfg_wr_en               cfg_index[1:0], cfg_data[31:0]
//
// one received byte per cycle while a frame is collected
// a frame end runs states SUB, F16A, F16B, F8A, F8B (fold) and DECIDE, in_ready low;
// then READ, LOAD per good body word via the store read port, or ERR per error word
// a waiting last result word does not block bytes of the next frame
// rst_n is synchronous; the frame store is not cleared, only written entries are read
// out_ready low holds the output word and stalls the drain

module stuffed_frame_receiver
  import sfr_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES   = 64,
  parameter int unsigned MIN_BODY_BYTES = 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [SUM_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [1:0]        out_status,
  output logic      [BYTE_W-1:0] out_data_byte,
  output logic      [IDX_W-1:0]  out_byte_index,
  output logic      [IDX_W-1:0]  out_frame_length,
  output logic                   out_last_item
);

  sfr_cmd_t  cmd;
  sfr_stat_t stat;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfr_datapath #(
    .BUFFER_BYTES   (BUFFER_BYTES),
    .MIN_BODY_BYTES (MIN_BODY_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_rx_byte       (in_rx_byte),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_data_byte    (out_data_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_last_item    (out_last_item),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule

`default_nettype wire

// ===== sim/stuffed_frame_receiver_test.sv =====
`timescale 1ns / 1ps

module stuffed_frame_receiver_test
  import sfr_pkg::*;
();

  localparam int BUF_BYTES  = 64;
  localparam int MIN_BODY   = 3;
  localparam int BODY_LIMIT = (BUF_BYTES / 2) < 32 ? (BUF_BYTES / 2) : 32;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_ITEMS = 5;
  localparam int NUM_PHASES  = 6;

  // one result word of the output channel
  typedef struct {
    status_t     status;
    logic [7:0]  data;
    logic [4:0]  idx;
    logic [4:0]  len;
    logic        last;
  } word_t;

  // directed row: byte to send, and the hand-typed word it ends on, if any
  typedef struct packed {
    logic [7:0] rx;
    logic       chk;
    status_t    st;
    logic [4:0] len;
  } row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [1:0]        cfg_index = CFG_FRAME_BYTE;
  logic [SUM_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_status;
  logic [BYTE_W-1:0] out_data_byte;
  logic [IDX_W-1:0]  out_byte_index;
  logic [IDX_W-1:0]  out_frame_length;
  logic              out_last_item;

  // shadow of the configuration registers
  logic [7:0]  frame_val = FRAME_BYTE_RST;
  logic [7:0]  escape_val = ESCAPE_BYTE_RST;
  logic [31:0] seed_val = SEED_RST;

  // predicted deframer state
  logic [7:0]  rx_buf [32];
  int unsigned rx_count = 0;
  logic [31:0] rx_sum = SEED_RST;
  logic [7:0]  rx_last = '0;
  logic        rx_esc = 1'b0;

  word_t expected_words [$];
  int    fail_count = 0;
  int    idle_cycles = 0;
  int    items_sent = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;

  row_t dir_rows [23] = '{
    '{8'h7E, 1'b1, STAT_TOO_FEW, 5'd0},
    '{8'h01, 1'b0, STAT_GOOD, 5'd0},
    '{8'h02, 1'b0, STAT_GOOD, 5'd0},
    '{8'h7E, 1'b1, STAT_TOO_FEW, 5'd1},
    '{8'h05, 1'b0, STAT_GOOD, 5'd0},
    '{8'h10, 1'b0, STAT_GOOD, 5'd0},
    '{8'h20, 1'b0, STAT_GOOD, 5'd0},
    '{8'h35, 1'b0, STAT_GOOD, 5'd0},
    '{8'h7E, 1'b1, STAT_GOOD, 5'd3},
    '{8'h7D, 1'b0, STAT_GOOD, 5'd0},
    '{8'h7E, 1'b0, STAT_GOOD, 5'd0},
    '{8'h7D, 1'b0, STAT_GOOD, 5'd0},
    '{8'h7D, 1'b0, STAT_GOOD, 5'd0},
    '{8'h7D, 1'b0, STAT_GOOD, 5'd0},
    '{8'h41, 1'b0, STAT_GOOD, 5'd0},
    '{8'hFF, 1'b0, STAT_GOOD, 5'd0},
    '{8'h3F, 1'b0, STAT_GOOD, 5'd0},
    '{8'h7E, 1'b1, STAT_GOOD, 5'd4},
    '{8'h00, 1'b0, STAT_GOOD, 5'd0},
    '{8'h00, 1'b0, STAT_GOOD, 5'd0},
    '{8'h00, 1'b0, STAT_GOOD, 5'd0},
    '{8'h01, 1'b0, STAT_GOOD, 5'd0},
    '{8'h7E, 1'b1, STAT_BAD_SUM, 5'd3}
  };

  stuffed_frame_receiver #(
    .BUFFER_BYTES  (BUF_BYTES),
    .MIN_BODY_BYTES(MIN_BODY)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_data_byte   (out_data_byte),
    .out_byte_index  (out_byte_index),
    .out_frame_length(out_frame_length),
    .out_last_item   (out_last_item)
  );

  always #1 clk = ~clk;

  // end-around fold of the 32-bit sum down to 8 bits
  function automatic logic [7:0] fold8(input logic [31:0] s);
    logic [31:0] x;
    x = s;
    x = x + (x >> 16);
    x = x + (x >> 16);
    x = x + (x >> 8);
    x = x + (x >> 8);
    return x[7:0];
  endfunction

  function automatic void restart_frame();
    rx_count = 0;
    rx_sum   = seed_val;
    rx_last  = '0;
    rx_esc   = 1'b0;
  endfunction

  // keep a literal byte; the count saturates at the buffer size
  function automatic void store_rx(input logic [7:0] b);
    if (rx_count < BUF_BYTES) begin
      if (rx_count < BODY_LIMIT) rx_buf[rx_count] = b;
      rx_sum  = rx_sum + {24'd0, b};
      rx_last = b;
      rx_count++;
    end
  endfunction

  // frame end: either one word per body byte or a single status word
  function automatic void close_frame();
    word_t       w;
    int unsigned n;
    int unsigned len;
    n = rx_count;
    w.data = '0;
    w.idx  = '0;
    w.last = 1'b1;
    if (n < MIN_BODY + 1) begin
      w.status = STAT_TOO_FEW;
      len = (n == 0) ? 0 : n - 1;
    end else if (n - 1 >= BODY_LIMIT) begin
      w.status = STAT_TOO_MANY;
      len = 31;
    end else begin
      len = n - 1;
      if (fold8(rx_sum - {24'd0, rx_last}) == rx_last) begin
        for (int k = 0; k < len; k++) begin
          w.status = STAT_GOOD;
          w.data   = rx_buf[k];
          w.idx    = k[4:0];
          w.len    = len[4:0];
          w.last   = (k + 1 == len);
          expected_words.push_back(w);
        end
        restart_frame();
        return;
      end
      w.status = STAT_BAD_SUM;
    end
    w.len = len[4:0];
    expected_words.push_back(w);
    restart_frame();
  endfunction

  // predictor: one accepted input word
  function automatic void deframe_byte(input logic [7:0] c);
    if (c == frame_val) begin
      if (!rx_esc) begin
        close_frame();
      end else begin
        store_rx(c);
        rx_esc = 1'b0;
      end
    end else if (c == escape_val) begin
      if (rx_esc) begin
        store_rx(c);
        rx_esc = 1'b0;
      end else begin
        rx_esc = 1'b1;
      end
    end else begin
      store_rx(c);
      rx_esc = 1'b0;
    end
  endfunction

  // random content byte, leaning toward the marker values
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    int         r;
    r = $urandom_range(9);
    if (frame_val != escape_val && r == 0) b = frame_val;
    else if (frame_val != escape_val && r == 1) b = escape_val;
    else b = $urandom_range(255);
    if (frame_val == escape_val && b == frame_val) b = b ^ 8'h01;
    return b;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_byte(b);
    items_sent++;
    @(negedge clk);
  endtask

  // stuffed send, with an occasional extra escape before a plain byte
  task automatic send_stuffed(input logic [7:0] b);
    if (frame_val != escape_val) begin
      if (b == frame_val || b == escape_val) send_byte(escape_val);
      else if ($urandom_range(19) == 0) send_byte(escape_val);
    end
    send_byte(b);
  endtask

  task automatic send_frame(input int body_len, input bit good_sum);
    logic [31:0] sum;
    logic [7:0]  b;
    logic [7:0]  chk;
    int          k;
    sum = rx_sum;
    for (k = 0; k < body_len; k++) begin
      b   = pick_byte();
      sum = sum + {24'd0, b};
      send_stuffed(b);
    end
    chk = fold8(sum);
    if (!good_sum) chk = chk ^ (8'd1 << $urandom_range(7));
    send_stuffed(chk);
    send_byte(frame_val);
  endtask

  // sender holds off until every expected word has come
  task automatic wait_drained(input int extra);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_FRAME_BYTE:    frame_val = val[7:0];
      CFG_ESCAPE_BYTE:   escape_val = val[7:0];
      CFG_CHECKSUM_SEED: seed_val = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // receiver side back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: status %0d data %0h index %0d length %0d last %0b",
               out_status, out_data_byte, out_byte_index, out_frame_length, out_last_item);
        fail_count++;
      end else begin
        w = expected_words.pop_front();
        if (out_status !== w.status) begin
          $error("status: expected %0d, actual %0d", w.status, out_status);
          fail_count++;
        end
        if (out_data_byte !== w.data) begin
          $error("data_byte: expected %0h, actual %0h", w.data, out_data_byte);
          fail_count++;
        end
        if (out_byte_index !== w.idx) begin
          $error("byte_index: expected %0d, actual %0d", w.idx, out_byte_index);
          fail_count++;
        end
        if (out_frame_length !== w.len) begin
          $error("frame_length: expected %0d, actual %0d", w.len, out_frame_length);
          fail_count++;
        end
        if (out_last_item !== w.last) begin
          $error("last_item: expected %0b, actual %0b", w.last, out_last_item);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("stuffed_frame_receiver_test: errors");
        $finish;
      end
    end
  end

  initial begin
    int          r;
    int          start_items;
    logic [7:0]  v;
    word_t       w;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows at reset settings
    for (int i = 0; i < 23; i++) begin
      send_byte(dir_rows[i].rx);
      if (dir_rows[i].chk) begin
        w = expected_words[$];
        if (w.status !== dir_rows[i].st || w.len !== dir_rows[i].len) begin
          $error("row %0d: expected status %0d length %0d, predicted status %0d length %0d",
                 i, dir_rows[i].st, dir_rows[i].len, w.status, w.len);
          fail_count++;
        end
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_drained(20);
        case (p)
          1: begin
            write_reg(CFG_FRAME_BYTE, 32'h00);
            write_reg(CFG_ESCAPE_BYTE, 32'hFF);
            write_reg(CFG_CHECKSUM_SEED, 32'hFFFF_FFFF);
          end
          2: begin
            write_reg(CFG_FRAME_BYTE, 32'hFF);
            write_reg(CFG_ESCAPE_BYTE, 32'h00);
            write_reg(CFG_CHECKSUM_SEED, $urandom);
          end
          3: begin
            // frame and escape markers equal: the frame rule wins
            v = $urandom_range(255);
            write_reg(CFG_FRAME_BYTE, {24'd0, v});
            write_reg(CFG_ESCAPE_BYTE, {24'd0, v});
            write_reg(CFG_CHECKSUM_SEED, 32'h8000_0000);
          end
          4: begin
            v = $urandom_range(255);
            write_reg(CFG_FRAME_BYTE, {24'd0, v});
            write_reg(CFG_ESCAPE_BYTE, {24'd0, v ^ 8'($urandom_range(255, 1))});
            write_reg(CFG_CHECKSUM_SEED, $urandom);
          end
          default: begin
            write_reg(CFG_FRAME_BYTE, {24'd0, FRAME_BYTE_RST});
            write_reg(CFG_ESCAPE_BYTE, {24'd0, ESCAPE_BYTE_RST});
            write_reg(CFG_CHECKSUM_SEED, SEED_RST);
          end
        endcase
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        // empty frame so the new seed takes hold
        send_byte(frame_val);
      end

      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase

      // size boundaries: longest good body, first too long, buffer overrun, shortest good, first too short
      if (p == 0) begin
        send_frame(BODY_LIMIT - 1, 1'b1);
        send_frame(BODY_LIMIT, 1'b1);
        send_frame(BUF_BYTES + 1, 1'b1);
        send_frame(MIN_BODY, 1'b1);
        send_frame(MIN_BODY - 1, 1'b1);
      end

      start_items = items_sent;
      while (items_sent - start_items < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 5) begin
          wait_drained(0);
          @(negedge clk);
        end else if (r < 15) begin
          // noise bytes, sometimes closed by a frame marker
          repeat ($urandom_range(6, 1)) send_byte(pick_byte());
          if ($urandom_range(1)) send_byte(frame_val);
        end else begin
          r = $urandom_range(99);
          if (r < 8) send_frame($urandom_range(MIN_BODY - 1), 1'b1);
          else if (r < 70) send_frame($urandom_range(12, MIN_BODY), $urandom_range(99) < 85);
          else if (r < 90) send_frame($urandom_range(31, 13), $urandom_range(99) < 85);
          else if (r < 98) send_frame($urandom_range(40, 32), 1'b1);
          else send_frame($urandom_range(70, 60), 1'b1);
        end
      end
    end

    wait_drained(40);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("stuffed_frame_receiver_test: clean");
    end else begin
      $display("stuffed_frame_receiver_test: errors");
    end
    $finish;
  end

endmodule
